[src/qrv_pkg.sv]
// Package for the quaternion vector rotation block: widths, thresholds, shared types.
// No dependencies; every other file imports it.
`default_nettype none
package qrv_pkg;
    localparam int DW  = 16;          // data field width
    localparam int QF  = 13;          // quaternion fraction bits
    localparam int PW  = 2 * DW;      // quaternion component product
    localparam int MW  = PW + 2;      // rotation matrix entry (times n2)
    localparam int NW  = PW + 2;      // squared norm
    localparam int VW  = MW + DW;     // matrix entry times vector component
    localparam int AW  = VW + 2;      // row sum of three products
    localparam int RW  = AW + 2;      // divider remainder: 2*|num| + n2
    localparam int DVW = NW + 1;      // divisor: 2*n2
    localparam int QB  = DW + 2;      // quotient bits
    localparam int FAW = 2;           // queue address bits
    localparam int FIFO_DEPTH = 2 ** FAW;

    // floor(2^(2*QF) / 10^12): norm^2 at or below this counts as zero
    localparam longint unsigned THR_L = (64'd1 << (2 * QF)) / 64'd1000000000000;
    localparam logic [NW-1:0] THR = NW'(THR_L);

    typedef struct packed {
        logic [8:0][MW-1:0] mat;   // n2-scaled rotation matrix, row major, signed
        logic [2:0][DW-1:0] vec;   // signed vector
        logic [NW-1:0]      n2;
        logic               degen;
    } t_front;

    typedef struct packed {
        logic [2:0][DW-1:0] vec;
        logic [DVW-1:0]     dvs;
        logic               degen;
        logic [2:0]         neg;
    } t_side;
endpackage
`default_nettype wire

[src/qrv_front.sv]
// Front end: accepts a transaction, forms quaternion products, builds the scaled matrix.
// Depends on qrv_pkg.
`default_nettype none
module qrv_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [qrv_pkg::DW-1:0]    i_quat_w,
    input  wire logic [qrv_pkg::DW-1:0]    i_quat_x,
    input  wire logic [qrv_pkg::DW-1:0]    i_quat_y,
    input  wire logic [qrv_pkg::DW-1:0]    i_quat_z,
    input  wire logic [qrv_pkg::DW-1:0]    i_vec_x,
    input  wire logic [qrv_pkg::DW-1:0]    i_vec_y,
    input  wire logic [qrv_pkg::DW-1:0]    i_vec_z,
    output qrv_pkg::t_front                o_item,
    output logic                           o_valid,
    input  wire logic                      i_ready
);
    import qrv_pkg::*;

    logic                     en;
    logic                     r_f1_v;
    logic signed [PW-1:0]     r_ww, r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic [2:0][DW-1:0]       r_f1_vec;
    logic                     r_f2_v;
    t_front                   r_f2, n_f2;
    logic signed [MW-1:0]     e_ww, e_xx, e_yy, e_zz, e_xy, e_xz, e_yz, e_wx, e_wy, e_wz;
    logic signed [DW-1:0]     qw, qx, qy, qz;

    assign en      = !r_f2_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_f2_v;
    assign o_item  = r_f2;

    assign qw = $signed(i_quat_w);
    assign qx = $signed(i_quat_x);
    assign qy = $signed(i_quat_y);
    assign qz = $signed(i_quat_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= i_valid;
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ww <= PW'(qw * qw);
            r_xx <= PW'(qx * qx);
            r_yy <= PW'(qy * qy);
            r_zz <= PW'(qz * qz);
            r_xy <= PW'(qx * qy);
            r_xz <= PW'(qx * qz);
            r_yz <= PW'(qy * qz);
            r_wx <= PW'(qw * qx);
            r_wy <= PW'(qw * qy);
            r_wz <= PW'(qw * qz);
            r_f1_vec <= {i_vec_z, i_vec_y, i_vec_x};
            r_f2 <= n_f2;
        end
    end

    always_comb begin
        e_ww = MW'(r_ww); e_xx = MW'(r_xx); e_yy = MW'(r_yy); e_zz = MW'(r_zz);
        e_xy = MW'(r_xy); e_xz = MW'(r_xz); e_yz = MW'(r_yz);
        e_wx = MW'(r_wx); e_wy = MW'(r_wy); e_wz = MW'(r_wz);
        n_f2.mat[0] = e_ww + e_xx - e_yy - e_zz;
        n_f2.mat[1] = (e_xy - e_wz) <<< 1;
        n_f2.mat[2] = (e_xz + e_wy) <<< 1;
        n_f2.mat[3] = (e_xy + e_wz) <<< 1;
        n_f2.mat[4] = e_ww - e_xx + e_yy - e_zz;
        n_f2.mat[5] = (e_yz - e_wx) <<< 1;
        n_f2.mat[6] = (e_xz - e_wy) <<< 1;
        n_f2.mat[7] = (e_yz + e_wx) <<< 1;
        n_f2.mat[8] = e_ww - e_xx - e_yy + e_zz;
        n_f2.n2     = NW'(e_ww + e_xx + e_yy + e_zz);
        n_f2.degen  = (n_f2.n2 <= THR);
        n_f2.vec    = r_f1_vec;
    end
endmodule
`default_nettype wire

[src/qrv_queue.sv]
// Short register queue between front and back ends.
// Depends on qrv_pkg.
`default_nettype none
module qrv_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire qrv_pkg::t_front  i_item,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output qrv_pkg::t_front       o_item
);
    import qrv_pkg::*;

    t_front         r_mem [FIFO_DEPTH];
    logic [FAW-1:0] r_wp, r_rp;
    logic [FAW:0]   r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != (FAW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FAW+1)'(push) - (FAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end
endmodule
`default_nettype wire

[src/qrv_back.sv]
// Back end: vector products, row sums, pipelined restoring divide by n2, round, saturate.
// Depends on qrv_pkg.
`default_nettype none
module qrv_back (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire qrv_pkg::t_front         i_item,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [qrv_pkg::DW-1:0]       o_rot_x,
    output logic [qrv_pkg::DW-1:0]       o_rot_y,
    output logic [qrv_pkg::DW-1:0]       o_rot_z,
    output logic                         o_degenerate,
    output logic                         o_saturated
);
    import qrv_pkg::*;

    logic                en;
    // products
    logic                r_b1_v;
    logic [8:0][VW-1:0]  r_b1_pr;
    t_front              r_b1_it;
    // row sums
    logic                r_b2_v;
    logic [2:0][AW-1:0]  r_b2_acc;
    t_front              r_b2_it;
    // divider pipeline, index 0 is the loaded dividend
    logic                r_dv  [QB+1];
    logic [2:0][RW-1:0]  r_rem [QB+1];
    logic [2:0][QB-1:0]  r_q   [QB+1];
    t_side               r_sd  [QB+1];
    logic [2:0][RW-1:0]  n_rem [QB+1];
    logic [2:0][QB-1:0]  n_q   [QB+1];
    // output
    logic                r_out_v;
    logic [2:0][DW-1:0]  r_rot, n_rot;
    logic                r_degen, r_sat, n_sat;

    logic [8:0][VW-1:0]  n_pr;
    logic [2:0][AW-1:0]  n_acc;
    logic [2:0][RW-1:0]  n_rem0;
    t_side               n_sd0;
    logic signed [MW-1:0] ms;
    logic signed [DW-1:0] vs;
    logic [AW-1:0]       amag;
    logic [RW-1:0]       cmp;
    logic [QB-1:0]       lim, qv, mv;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_out_v;
    assign o_rot_x = r_rot[0];
    assign o_rot_y = r_rot[1];
    assign o_rot_z = r_rot[2];
    assign o_degenerate = r_degen;
    assign o_saturated  = r_sat;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            ms = $signed(i_item.mat[k]);
            vs = $signed(i_item.vec[k % 3]);
            n_pr[k] = VW'(ms * vs);
        end
        for (int r = 0; r < 3; r++) begin
            n_acc[r] = AW'($signed(r_b1_pr[3*r])) + AW'($signed(r_b1_pr[3*r+1]))
                     + AW'($signed(r_b1_pr[3*r+2]));
        end
        // dividend 2*|num| + n2 against divisor 2*n2 gives round half away from zero
        n_sd0.vec   = r_b2_it.vec;
        n_sd0.degen = r_b2_it.degen;
        n_sd0.dvs   = {r_b2_it.n2, 1'b0};
        for (int r = 0; r < 3; r++) begin
            n_sd0.neg[r] = r_b2_acc[r][AW-1];
            amag = n_sd0.neg[r] ? (~r_b2_acc[r] + 1'b1) : r_b2_acc[r];
            n_rem0[r] = {1'b0, amag, 1'b0} + RW'(r_b2_it.n2);
        end
    end

    always_comb begin
        n_rem[0] = r_rem[0];
        n_q[0]   = r_q[0];
        for (int k = 0; k < QB; k++) begin
            for (int c = 0; c < 3; c++) begin
                cmp = RW'(r_sd[k].dvs) << (QB - 1 - k);
                n_rem[k+1][c] = r_rem[k][c];
                n_q[k+1][c]   = r_q[k][c];
                if (r_rem[k][c] >= cmp) begin
                    n_rem[k+1][c] = r_rem[k][c] - cmp;
                    n_q[k+1][c][QB-1-k] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            qv  = r_q[QB][c];
            lim = r_sd[QB].neg[c] ? QB'(1 << (DW-1)) : QB'((1 << (DW-1)) - 1);
            mv  = qv;
            if (qv > lim) begin
                mv = lim;
                n_sat = 1'b1;
            end
            n_rot[c] = r_sd[QB].neg[c] ? (~mv[DW-1:0] + 1'b1) : mv[DW-1:0];
        end
        // zero quaternion: pass the vector as is
        if (r_sd[QB].degen) begin
            n_rot = r_sd[QB].vec;
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_b2_v  <= 1'b0;
            r_out_v <= 1'b0;
            for (int k = 0; k <= QB; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_b1_v  <= i_valid;
            r_b2_v  <= r_b1_v;
            r_dv[0] <= r_b2_v;
            for (int k = 0; k < QB; k++) r_dv[k+1] <= r_dv[k];
            r_out_v <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b1_pr  <= n_pr;
            r_b1_it  <= i_item;
            r_b2_acc <= n_acc;
            r_b2_it  <= r_b1_it;
            r_rem[0] <= n_rem0;
            r_q[0]   <= '0;
            r_sd[0]  <= n_sd0;
            for (int k = 0; k < QB; k++) begin
                r_rem[k+1] <= n_rem[k+1];
                r_q[k+1]   <= n_q[k+1];
                r_sd[k+1]  <= r_sd[k];
            end
            r_rot   <= n_rot;
            r_sat   <= n_sat;
            r_degen <= r_sd[QB].degen;
        end
    end
endmodule
`default_nettype wire

[src/quaternion_rotate_vector.sv]
// Rotates a vector by a normalized quaternion: a front end forms the scaled matrix,
// a four-entry queue decouples it from the back end, which divides by the norm squared.
// Throughput: one transaction per cycle while i_ready stays high; each divider stage resolves one quotient bit.
// Path: front product and matrix registers, the queue, then back product, row-sum, divider and output registers.
// Reset: synchronous active-low i_rst_n clears all valid flags and the queue; data registers are not reset.
`default_nettype none
module quaternion_rotate_vector (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [qrv_pkg::DW-1:0]  i_quat_w,
    input  wire logic [qrv_pkg::DW-1:0]  i_quat_x,
    input  wire logic [qrv_pkg::DW-1:0]  i_quat_y,
    input  wire logic [qrv_pkg::DW-1:0]  i_quat_z,
    input  wire logic [qrv_pkg::DW-1:0]  i_vec_x,
    input  wire logic [qrv_pkg::DW-1:0]  i_vec_y,
    input  wire logic [qrv_pkg::DW-1:0]  i_vec_z,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [qrv_pkg::DW-1:0]       o_rot_x,
    output logic [qrv_pkg::DW-1:0]       o_rot_y,
    output logic [qrv_pkg::DW-1:0]       o_rot_z,
    output logic                         o_degenerate,
    output logic                         o_saturated
);
    import qrv_pkg::*;

    t_front f_item, q_item;
    logic   f_valid, f_ready, q_valid, q_ready;

    qrv_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_quat_w, .i_quat_x, .i_quat_y, .i_quat_z,
        .i_vec_x, .i_vec_y, .i_vec_z,
        .o_item(f_item), .o_valid(f_valid), .i_ready(f_ready)
    );

    qrv_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(f_valid), .o_ready(f_ready), .i_item(f_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    qrv_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid, .i_ready,
        .o_rot_x, .o_rot_y, .o_rot_z, .o_degenerate, .o_saturated
    );
endmodule
`default_nettype wire

[src/qrv_checker.sv]
// Port-level checks for the rotation block, bound to the top level.
// Depends on qrv_pkg.
`default_nettype none
module qrv_checker (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    o_valid,
    input wire logic                    i_ready,
    input wire logic [qrv_pkg::DW-1:0]  o_rot_x,
    input wire logic [qrv_pkg::DW-1:0]  o_rot_y,
    input wire logic [qrv_pkg::DW-1:0]  o_rot_z,
    input wire logic                    o_degenerate,
    input wire logic                    o_saturated
);
    import qrv_pkg::*;

    localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

    // hold a stalled transaction: valid, o_rot_x and o_saturated stay stable
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rot_x) && $stable(o_saturated))
        else $error("output transaction changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> !o_saturated)
        else $error("identity pass-through flagged as saturated");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> (o_rot_x == MAXV || o_rot_x == MINV ||
            o_rot_y == MAXV || o_rot_y == MINV || o_rot_z == MAXV || o_rot_z == MINV))
        else $error("saturation flag without a clipped component");
endmodule

bind quaternion_rotate_vector qrv_checker u_qrv_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready,
    .o_rot_x, .o_rot_y, .o_rot_z, .o_degenerate, .o_saturated
);
`default_nettype wire
